FILE: hdl/assert_macros.svh
// shared assertion shorthands for the fall detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define FITD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked property that is also checked during reset
`define FITD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/fitd_pkg.sv
package fitd_pkg;

   // field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int TIME_BITS      = 32;
   localparam int SQ_BITS        = 2 * SAMPLE_BITS;
   localparam int SUM_BITS       = SQ_BITS + 2;
   localparam int MAG_BITS       = 32;
   localparam int CFG_BITS       = 16;
   localparam int THR_SQ_BITS    = 2 * CFG_BITS;
   localparam int LIMIT_BITS     = CFG_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   // elapsed time against the disarm bound, wide enough for both
   localparam int CMP_BITS       = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

   // register reset values
   localparam logic [CFG_BITS-1:0] SPIKE_RESET      = CFG_BITS'(6272);
   localparam logic [CFG_BITS-1:0] STILL_RESET      = CFG_BITS'(256);
   localparam logic [CFG_BITS-1:0] STILL_TIME_RESET = CFG_BITS'(2000);
   localparam logic [CFG_BITS-1:0] GRACE_RESET      = CFG_BITS'(1000);
   localparam logic [CFG_BITS-1:0] WAKE_RESET       = CFG_BITS'(256);

   localparam logic [THR_SQ_BITS-1:0] SPIKE_SQ_RESET =
      THR_SQ_BITS'(SPIKE_RESET) * THR_SQ_BITS'(SPIKE_RESET);
   localparam logic [THR_SQ_BITS-1:0] STILL_SQ_RESET =
      THR_SQ_BITS'(STILL_RESET) * THR_SQ_BITS'(STILL_RESET);
   localparam logic [THR_SQ_BITS-1:0] WAKE_SQ_RESET =
      THR_SQ_BITS'(WAKE_RESET) * THR_SQ_BITS'(WAKE_RESET);

   localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SPIKE_THRESHOLD = CSR_INDEX_BITS'(0),
      REG_STILL_THRESHOLD = CSR_INDEX_BITS'(1),
      REG_STILL_TIME_MS   = CSR_INDEX_BITS'(2),
      REG_GRACE_MS        = CSR_INDEX_BITS'(3),
      REG_WAKE_THRESHOLD  = CSR_INDEX_BITS'(4)
   } reg_index_type;

   // thresholds as the datapath consumes them
   typedef struct packed {
      logic [THR_SQ_BITS-1:0] spike_sq;
      logic [THR_SQ_BITS-1:0] still_sq;
      logic [THR_SQ_BITS-1:0] wake_sq;
      logic [CFG_BITS-1:0]    still_time;
      logic [LIMIT_BITS-1:0]  disarm_limit;
   } thr_type;

   // square of a two's complement sample, most negative value included
   function automatic logic [SQ_BITS-1:0] square_sample(input logic [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] mag;
      logic [SQ_BITS-1:0]     wide;
      mag  = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : v;
      wide = SQ_BITS'(mag);
      return wide * wide;
   endfunction

endpackage

FILE: hdl/fitd_csr.sv
module fitd_csr
   import fitd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data,
   output thr_type                   thr
);

   logic [THR_SQ_BITS-1:0] spike_sq_ff, still_sq_ff, wake_sq_ff;
   logic [THR_SQ_BITS-1:0] data_sq;
   logic [CFG_BITS-1:0]    still_time_ff, grace_ff;
   logic                   wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // thresholds are kept squared so the datapath never needs a root
   assign data_sq = THR_SQ_BITS'(csr_data) * THR_SQ_BITS'(csr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_sq_ff   <= SPIKE_SQ_RESET;
         still_sq_ff   <= STILL_SQ_RESET;
         wake_sq_ff    <= WAKE_SQ_RESET;
         still_time_ff <= STILL_TIME_RESET;
         grace_ff      <= GRACE_RESET;
      end else if (wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_SPIKE_THRESHOLD: spike_sq_ff   <= data_sq;
            REG_STILL_THRESHOLD: still_sq_ff   <= data_sq;
            REG_STILL_TIME_MS:   still_time_ff <= csr_data;
            REG_GRACE_MS:        grace_ff      <= csr_data;
            REG_WAKE_THRESHOLD:  wake_sq_ff    <= data_sq;
            default: ;
         endcase
      end
   end

   always_comb begin
      thr.spike_sq     = spike_sq_ff;
      thr.still_sq     = still_sq_ff;
      thr.wake_sq      = wake_sq_ff;
      thr.still_time   = still_time_ff;
      thr.disarm_limit = LIMIT_BITS'(still_time_ff) + LIMIT_BITS'(grace_ff);
   end

endmodule

FILE: hdl/impact_then_stillness_fall_detector_unit.sv
// channel   direction  handshake          payload
// req_      in         req_valid/stall    accel_x, accel_y, accel_z, time_ms
// rsp_      out        rsp_valid/stall    fall_event, fall_latched, armed, wake, magnitude_sq
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// one request per cycle sustained while rsp_stall is low; each result passes the stage one and output registers
// stage one registers the sample, stage two squares, sums, compares and updates the flags
// synchronous active-high reset clears the armed and fall flags, valid bits and thresholds to defaults
// a stalled result holds in the output register; the input stage still takes one more
// request, and req_stall rises only once both stages are full
module impact_then_stillness_fall_detector_unit
   import fitd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic [TIME_BITS-1:0]      req_time_ms,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_fall_event,
   output logic                      rsp_fall_latched,
   output logic                      rsp_armed,
   output logic                      rsp_wake,
   output logic [MAG_BITS-1:0]       rsp_magnitude_sq,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

`include "assert_macros.svh"

   thr_type thr;

   fitd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .thr       (thr)
   );

   // pipeline control
   logic s1_valid_ff, out_valid_ff;
   logic out_adv, s1_adv, req_take;

   assign out_adv   = !out_valid_ff || !rsp_stall;   // output register can load
   assign s1_adv    = s1_valid_ff && out_adv;        // stage one moves forward
   assign req_stall = s1_valid_ff && !out_adv;
   assign req_take  = req_valid && !req_stall;

   // stage one: input register, raw axes and the timestamp
   logic [SAMPLE_BITS-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_BITS-1:0]   s1_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff      <= req_accel_x;
         ay_ff      <= req_accel_y;
         az_ff      <= req_accel_z;
         s1_time_ff <= req_time_ms;
      end
   end

   // stage two: magnitude, compares and detector state
   logic [SUM_BITS-1:0]  msq;
   logic                 spike_hit, still_hit, wake_hit;
   logic                 arm_new, armed_now;
   logic [TIME_BITS-1:0] spike_base, elapsed;

   logic                 armed_ff, fall_ff;
   logic [TIME_BITS-1:0] spike_time_ff;
   logic                 armed_in, fall_in, event_in;
   logic [TIME_BITS-1:0] spike_time_in;

   assign msq = SUM_BITS'(square_sample(ax_ff)) + SUM_BITS'(square_sample(ay_ff)) +
                SUM_BITS'(square_sample(az_ff));

   assign spike_hit = msq > SUM_BITS'(thr.spike_sq);
   assign still_hit = msq < SUM_BITS'(thr.still_sq);
   assign wake_hit  = msq > SUM_BITS'(thr.wake_sq);

   // arming happens first, so a spike sample is checked at zero elapsed time
   assign arm_new    = !armed_ff && spike_hit;
   assign armed_now  = armed_ff || arm_new;
   assign spike_base = arm_new ? s1_time_ff : spike_time_ff;
   assign elapsed    = s1_time_ff - spike_base;   // wraps with the timestamp

   always_comb begin
      armed_in      = armed_now;
      fall_in       = fall_ff;
      event_in      = 1'b0;
      spike_time_in = spike_base;
      // once a fall is latched the checks stop, so armed may stick
      if (armed_now && !fall_ff) begin
         if (still_hit) begin
            if (elapsed >= TIME_BITS'(thr.still_time)) begin
               fall_in  = 1'b1;
               event_in = 1'b1;
               armed_in = 1'b0;
            end
         end else if (CMP_BITS'(elapsed) > CMP_BITS'(thr.disarm_limit)) begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         fall_ff       <= 1'b0;
         spike_time_ff <= '0;
      end else if (s1_adv) begin
         armed_ff      <= armed_in;
         fall_ff       <= fall_in;
         spike_time_ff <= spike_time_in;
      end
   end

   // output register
   logic                event_ff, wake_ff;
   logic [MAG_BITS-1:0] mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         event_ff <= event_in;
         wake_ff  <= wake_hit;
         // saturate if the sum outgrows the result field
         mag_ff   <= (msq > SUM_BITS'(MAG_MAX)) ? MAG_MAX : MAG_BITS'(msq);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_fall_event   = event_ff;
   assign rsp_fall_latched = fall_ff;
   assign rsp_armed        = armed_ff;
   assign rsp_wake         = wake_ff;
   assign rsp_magnitude_sq = mag_ff;

   // a declared fall always shows latched and disarmed
   `FITD_ASSERT(a_event_latched, rsp_valid && rsp_fall_event |-> rsp_fall_latched && !rsp_armed, "fall event without latched flag or still armed")

   // the fall flag never clears outside reset
   `FITD_ASSERT(a_fall_sticky, fall_ff && !reset |=> fall_ff, "fall flag cleared without reset")

   // the input side only waits when both stages hold a request
   `FITD_ASSERT_ALWAYS(a_stall_full, req_stall |-> s1_valid_ff && out_valid_ff, "input stalled with a free stage")

   // detector state moves only when a request reaches the output register
   `FITD_ASSERT(a_state_hold, !s1_adv && !reset |=> $stable(fall_ff) && $stable(armed_ff), "detector state changed without a request")

endmodule

FILE: sim/impact_then_stillness_fall_detector_unit_tb.sv
`timescale 1ns / 100ps

module impact_then_stillness_fall_detector_unit_tb;
   import fitd_pkg::*;

   // one sample as it enters the detector
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] ax;
      logic [SAMPLE_BITS-1:0] ay;
      logic [SAMPLE_BITS-1:0] az;
      logic [TIME_BITS-1:0]   stamp;
   } sample_type;

   // one detector report as it leaves
   typedef struct packed {
      logic                fall_event;
      logic                fall_latched;
      logic                armed;
      logic                wake;
      logic [MAG_BITS-1:0] magnitude_sq;
   } report_type;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // one line of the directed walk: either a register write or a sample
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CFG_BITS-1:0]       data;
      sample_type                smp;
      bit                        fixed;
      report_type                want;
   } dir_row_type;

   // settings for one stretch of random traffic
   typedef struct packed {
      logic [CFG_BITS-1:0] spike;
      logic [CFG_BITS-1:0] still;
      logic [CFG_BITS-1:0] hold_ms;
      logic [CFG_BITS-1:0] grace;
      logic [CFG_BITS-1:0] wake;
      int                  step_max;
      int                  count;
      bit                  steady;
      bit                  jumps;
      bit                  holdoff;
   } phase_type;

   typedef enum {SHAPE_MOTION, SHAPE_STILL, SHAPE_EDGE, SHAPE_MILD} shape_type;

   // register indexes the block does not decode, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_LO = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_HI = CSR_INDEX_BITS'(7);
   localparam int AXIS_FLOOR     = 1 << (SAMPLE_BITS - 1);
   localparam int HOLDOFF_CYCLES = 48;
   localparam int PHASE_COUNT    = 6;

   // every input starts at a known value
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_accel_x = '0;
   logic signed [SAMPLE_BITS-1:0] req_accel_y = '0;
   logic signed [SAMPLE_BITS-1:0] req_accel_z = '0;
   logic [TIME_BITS-1:0]          req_time_ms = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_fall_event;
   logic                          rsp_fall_latched;
   logic                          rsp_armed;
   logic                          rsp_wake;
   logic [MAG_BITS-1:0]           rsp_magnitude_sq;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CFG_BITS-1:0]           csr_data = '0;

   impact_then_stillness_fall_detector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fall_event   (rsp_fall_event),
      .rsp_fall_latched (rsp_fall_latched),
      .rsp_armed        (rsp_armed),
      .rsp_wake         (rsp_wake),
      .rsp_magnitude_sq (rsp_magnitude_sq),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow copy of the thresholds, tracks every accepted register write
   logic [CFG_BITS-1:0]  cfg_spike      = SPIKE_RESET;
   logic [CFG_BITS-1:0]  cfg_still      = STILL_RESET;
   logic [CFG_BITS-1:0]  cfg_still_time = STILL_TIME_RESET;
   logic [CFG_BITS-1:0]  cfg_grace      = GRACE_RESET;
   logic [CFG_BITS-1:0]  cfg_wake       = WAKE_RESET;

   // detector state as the block should hold it
   bit                   det_armed    = 1'b0;
   bit                   det_fall     = 1'b0;
   logic [TIME_BITS-1:0] det_spike_ms = '0;

   // reports owed by the block, oldest first
   report_type  awaited[$];
   dir_row_type directed_rows[$];

   int  mismatches      = 0;
   int  requests_sent   = 0;
   int  reports_checked = 0;
   int  falls_seen      = 0;
   int  arms_predicted  = 0;
   bit  steady          = 1'b0;
   bit  holdoff_request = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the handshakes hang
   initial begin
      #4_000_000;
      $display("impact_then_stillness_fall_detector_unit regression: fail");
      $finish;
   end

   function automatic longint unsigned axis_energy(logic signed [SAMPLE_BITS-1:0] a);
      longint v;
      v = a;
      return longint'(v * v);
   endfunction

   function automatic longint unsigned thr_sq(logic [CFG_BITS-1:0] t);
      longint unsigned w;
      w = t;
      return w * w;
   endfunction

   // expected report for one accepted sample, advances the shadow state
   function automatic report_type predict_report(sample_type s);
      report_type           r;
      longint unsigned      msq;
      logic [TIME_BITS-1:0] since;
      msq = axis_energy(s.ax) + axis_energy(s.ay) + axis_energy(s.az);
      r = '0;
      r.wake = msq > thr_sq(cfg_wake);
      // arming comes first, so a spike sample runs the checks at zero elapsed
      if (!det_armed && msq > thr_sq(cfg_spike)) begin
         det_armed    = 1'b1;
         det_spike_ms = s.stamp;
         arms_predicted++;
      end
      // once a fall is latched the checks stop for good
      if (det_armed && !det_fall) begin
         since = s.stamp - det_spike_ms;
         if (msq < thr_sq(cfg_still)) begin
            if (since >= cfg_still_time) begin
               det_fall     = 1'b1;
               det_armed    = 1'b0;
               r.fall_event = 1'b1;
            end
         end else if (33'(since) > 33'(cfg_still_time) + 33'(cfg_grace)) begin
            det_armed = 1'b0;
         end
      end
      r.fall_latched = det_fall;
      r.armed        = det_armed;
      r.magnitude_sq = (msq > longint'(MAG_MAX)) ? MAG_MAX : msq[MAG_BITS-1:0];
      return r;
   endfunction

   function automatic void shadow_write(logic [CSR_INDEX_BITS-1:0] idx,
                                        logic [CFG_BITS-1:0] val);
      case (idx)
         REG_SPIKE_THRESHOLD: cfg_spike      = val;
         REG_STILL_THRESHOLD: cfg_still      = val;
         REG_STILL_TIME_MS:   cfg_still_time = val;
         REG_GRACE_MS:        cfg_grace      = val;
         REG_WAKE_THRESHOLD:  cfg_wake       = val;
         default: ;
      endcase
   endfunction

   // random idle run that grows while an 18 in 100 draw succeeds, none when steady
   function automatic int idle_run();
      int n;
      n = 0;
      if (steady) return 0;
      while (n < 8 && $urandom_range(99) < 18) n++;
      return n;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] signed_axis(int m);
      if (m >= AXIS_FLOOR) return SAMPLE_BITS'(AXIS_FLOOR);
      if ($urandom_range(1) == 1) return SAMPLE_BITS'(-m);
      return SAMPLE_BITS'(m);
   endfunction

   // sample shaped against the thresholds now in force
   function automatic sample_type make_sample(shape_type shape, logic [TIME_BITS-1:0] stamp);
      sample_type          s;
      int                  m;
      int                  axis;
      logic [CFG_BITS-1:0] thr;
      s = '0;
      s.stamp = stamp;
      case (shape)
         SHAPE_MOTION: begin
            s.ax = SAMPLE_BITS'($urandom);
            s.ay = SAMPLE_BITS'($urandom);
            s.az = SAMPLE_BITS'($urandom);
         end
         SHAPE_STILL: begin
            // each axis at most half a nonzero threshold keeps the sum strictly below it
            m = cfg_still / 2;
            s.ax = signed_axis($urandom_range(m, 0));
            s.ay = signed_axis($urandom_range(m, 0));
            s.az = signed_axis($urandom_range(m, 0));
         end
         SHAPE_MILD: begin
            m = (cfg_wake >= AXIS_FLOOR) ? AXIS_FLOOR - 1 : cfg_wake;
            s.ax = signed_axis($urandom_range(m, 0));
            s.ay = signed_axis($urandom_range(m, 0));
            s.az = signed_axis($urandom_range(m, 0));
         end
         default: begin
            // one axis at a threshold, one below or one above
            case ($urandom_range(2))
               0:       thr = cfg_spike;
               1:       thr = cfg_still;
               default: thr = cfg_wake;
            endcase
            m = int'(thr) + int'($urandom_range(2)) - 1;
            if (m < 0) m = 0;
            if (m > AXIS_FLOOR) m = AXIS_FLOOR;
            axis = $urandom_range(2);
            if (axis == 0) s.ax = signed_axis(m);
            else if (axis == 1) s.ay = signed_axis(m);
            else s.az = signed_axis(m);
         end
      endcase
      return s;
   endfunction

   function automatic void add_sample(int x, int y, int z, logic [TIME_BITS-1:0] t);
      dir_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.smp.ax = SAMPLE_BITS'(x);
      row.smp.ay = SAMPLE_BITS'(y);
      row.smp.az = SAMPLE_BITS'(z);
      row.smp.stamp = t;
      directed_rows.push_back(row);
   endfunction

   // sample whose report is plain from the fields alone
   function automatic void add_fixed(int x, int y, int z, logic [TIME_BITS-1:0] t,
                                     bit ev, bit lat, bit arm, bit wk,
                                     logic [MAG_BITS-1:0] msq);
      dir_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.smp.ax = SAMPLE_BITS'(x);
      row.smp.ay = SAMPLE_BITS'(y);
      row.smp.az = SAMPLE_BITS'(z);
      row.smp.stamp = t;
      row.fixed = 1'b1;
      row.want  = '{ev, lat, arm, wk, msq};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CFG_BITS-1:0] val);
      dir_row_type row;
      row = '0;
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.data  = val;
      directed_rows.push_back(row);
   endfunction

   // offer one request, hold it until taken, then log what it should produce
   task automatic push_request(sample_type s, bit fixed, report_type want);
      int         gap;
      report_type predicted;
      gap = idle_run();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= s.ax;
      req_accel_y <= s.ay;
      req_accel_z <= s.az;
      req_time_ms <= s.stamp;
      do @(posedge clock); while (req_stall);
      // the predictor runs for fixed rows too, so its state stays in step
      predicted = predict_report(s);
      awaited.push_back(fixed ? want : predicted);
      requests_sent++;
   endtask

   // stop offering and let every owed report drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays up, the caller lowers it after the last write
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      shadow_write(idx, val);
   endtask

   task automatic load_phase(phase_type ph);
      wait_idle();
      write_reg(REG_SPIKE_THRESHOLD, ph.spike);
      write_reg(REG_STILL_THRESHOLD, ph.still);
      write_reg(REG_STILL_TIME_MS, ph.hold_ms);
      write_reg(REG_GRACE_MS, ph.grace);
      write_reg(REG_WAKE_THRESHOLD, ph.wake);
      csr_valid <= 1'b0;
   endtask

   task automatic compare_field(string name, logic [MAG_BITS-1:0] want,
                                logic [MAG_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report();
      report_type want;
      if (awaited.size() == 0) begin
         $error("report arrived with no request outstanding");
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      compare_field("fall_event", want.fall_event, rsp_fall_event);
      compare_field("fall_latched", want.fall_latched, rsp_fall_latched);
      compare_field("armed", want.armed, rsp_armed);
      compare_field("wake", want.wake, rsp_wake);
      compare_field("magnitude_sq", want.magnitude_sq, rsp_magnitude_sq);
      reports_checked++;
      if (rsp_fall_event === 1'b1) falls_seen++;
   endtask

   // report side: take, check, then pick the stall for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_report();
         // one long hold-off so the pipeline backs up into req_stall
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(99) < 18);
      end
   end

   // request side: directed walk, then random phases
   initial begin
      phase_type            phases[PHASE_COUNT];
      logic [TIME_BITS-1:0] stamp_now;
      shape_type            shape;
      int                   left_in_episode;
      int                   done;
      int                   r;

      // reset held at the start, never again
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: spike 6272, still 256, still time 2000, grace 1000, wake 256
      add_fixed(0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
      // most negative on all axes: largest magnitude, arms at zero elapsed
      add_fixed(-32768, -32768, -32768, 16, 0, 0, 1, 1, 32'hC000_0000);
      // motion exactly at still time plus grace stays armed
      add_fixed(32767, 32767, 32767, 3016, 0, 0, 1, 1, 32'hBFFD_0003);
      // magnitude equal to still and wake thresholds: neither still nor awake, disarms
      add_fixed(0, 0, 256, 3017, 0, 0, 0, 0, 32'h0001_0000);
      add_sample(0, 257, 0, 3020);
      // magnitude equal to spike threshold does not arm
      add_fixed(0, 0, 6272, 3030, 0, 0, 0, 1, 32'h0258_4000);
      // arm just before the timestamp wraps, then check elapsed across the wrap
      add_sample(6273, 0, 0, 32'hFFFF_FF00);
      add_sample(0, 0, 0, 32'h0000_0100);
      add_sample(1000, -1000, 0, 32'h0000_0AB8);
      add_sample(1000, -1000, 0, 32'h0000_0AB9);
      // still above spike so one sample both arms and reads as still
      add_write(REG_STILL_THRESHOLD, 16'd500);
      add_write(REG_SPIKE_THRESHOLD, 16'd100);
      add_write(REG_STILL_TIME_MS, 16'hFFFF);
      add_write(REG_GRACE_MS, 16'hFFFF);
      add_write(REG_WAKE_THRESHOLD, 16'd0);
      // undecoded indexes must leave every threshold alone
      add_write(REG_UNUSED_LO, 16'hFFFF);
      add_write(REG_UNUSED_HI, 16'h0001);
      add_sample(0, 200, 0, 5);
      add_fixed(0, 0, 0, 65539, 0, 0, 1, 0, 32'h0000_0000);
      // grace bound of 131070 needs the seventeenth bit
      add_sample(-32768, 0, 0, 131075);
      add_fixed(32767, -32768, 1, 131076, 0, 0, 0, 1, 32'h7FFF_0002);
      // spike threshold at its top can never be crossed
      add_write(REG_SPIKE_THRESHOLD, 16'hFFFF);
      add_sample(-32768, -32768, -32768, 200000);
      add_write(REG_STILL_THRESHOLD, 16'hFFFF);
      add_sample(-1, 1, -1, 200001);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(directed_rows[i].index, directed_rows[i].data);
            if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_WRITE)
               csr_valid <= 1'b0;
         end else begin
            push_request(directed_rows[i].smp, directed_rows[i].fixed, directed_rows[i].want);
         end
      end

      // falls latch for good, so every phase before the last keeps them out of reach:
      // still threshold zero, or still time far beyond the time the phase covers
      phases[0] = '{16'd6272, 16'd0, 16'd0, 16'd0, 16'hFFFF, 50, 200, 1'b0, 1'b1, 1'b0};
      phases[1] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 30000, 200, 1'b1, 1'b1, 1'b0};
      phases[2] = '{16'hFFFF, 16'd0, 16'd500, 16'd250, 16'd32768, 500, 100, 1'b0, 1'b1, 1'b0};
      phases[3] = '{16'd12000, 16'd0, 16'd1500, 16'd800, 16'd256, 1000, 250, 1'b0, 1'b1, 1'b1};
      // stillness seen long before the still time, no time jumps here
      phases[4] = '{16'd8000, 16'd3000, 16'hFFFF, 16'd100, 16'd1000, 200, 150, 1'b0, 1'b0, 1'b0};
      // reset defaults: falls declared, then re-arming after the latch
      phases[5] = '{16'd6272, 16'd256, 16'd2000, 16'd1000, 16'd256, 800, 225, 1'b0, 1'b1, 1'b0};

      stamp_now = 32'd300000;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         // sender pauses here until every owed report is back
         load_phase(phases[p]);
         steady = phases[p].steady;
         if (phases[p].holdoff) holdoff_request = 1'b1;
         left_in_episode = 0;
         done = 0;
         while (done < phases[p].count) begin
            r = $urandom_range(99);
            if (phases[p].jumps && r < 5) stamp_now = $urandom();
            else if (r >= 10) stamp_now = stamp_now + $urandom_range(phases[p].step_max, 1);
            // an episode is an impact followed by a run of shaped samples
            if (left_in_episode == 0) begin
               shape = SHAPE_MOTION;
               left_in_episode = $urandom_range(8, 1);
            end else begin
               r = $urandom_range(99);
               if (r < 35) shape = SHAPE_STILL;
               else if (r < 60) shape = SHAPE_MOTION;
               else if (r < 80) shape = SHAPE_EDGE;
               else shape = SHAPE_MILD;
               left_in_episode--;
            end
            push_request(make_sample(shape, stamp_now), 1'b0, '0);
            done++;
         end
      end
      steady = 1'b0;

      wait_idle();
      // pipeline is two deep, the extra wait catches any stray report
      repeat (8) @(posedge clock);

      $display("%0d samples sent (directed walk and %0d random phases), %0d reports checked",
               requests_sent, PHASE_COUNT, reports_checked);
      $display("detector armed %0d times, %0d fall reported, %0d mismatches",
               arms_predicted, falls_seen, mismatches);
      if (mismatches == 0) begin
         $display("impact_then_stillness_fall_detector_unit regression: pass");
      end else begin
         $display("impact_then_stillness_fall_detector_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: impact_then_stillness_fall_detector_unit.f
+incdir+hdl
hdl/fitd_pkg.sv
hdl/fitd_csr.sv
hdl/impact_then_stillness_fall_detector_unit.sv
sim/impact_then_stillness_fall_detector_unit_tb.sv
